### rtl/gtpp_pkg.sv
// Shared types and constants of the greedy triangle pair partition block.
package gtpp_pkg;

  localparam int unsigned TriangleCapacity = 1024;
  localparam int unsigned TriIdxW          = $clog2(TriangleCapacity);
  localparam int unsigned CountW           = TriIdxW + 1;
  localparam int unsigned PairCountBits    = 12;
  localparam int unsigned FuncW            = 2;
  localparam int unsigned KindW            = 2;

  localparam logic [CountW-1:0]        TriCountReset = CountW'(TriangleCapacity);
  localparam logic [CountW-1:0]        TriCountMax   = CountW'(TriangleCapacity);
  localparam logic [TriIdxW-1:0]       LastTriIdx    = TriIdxW'(TriangleCapacity - 1);
  localparam logic [PairCountBits-1:0] PairCountMax  = {PairCountBits{1'b1}};

  // Request function codes; the fourth code has no meaning and is ignored.
  localparam logic [FuncW-1:0] FuncPair    = 2'd0;
  localparam logic [FuncW-1:0] FuncQuery   = 2'd1;
  localparam logic [FuncW-1:0] FuncRestart = 2'd2;

  typedef enum logic [KindW-1:0] {
    KIND_SHARED    = 2'd0,
    KIND_NONSHARED = 2'd1,
    KIND_UNVISITED = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef logic [TriIdxW-1:0] tri_idx_t;

  // Write to the mark store: set both addressed marks, or clear one entry.
  typedef struct packed {
    logic     en;
    logic     set;
    tri_idx_t first;
    tri_idx_t second;
  } mark_wr_t;

  // Read of the mark store at two addresses.
  typedef struct packed {
    logic     en;
    tri_idx_t first;
    tri_idx_t second;
  } mark_rd_t;

endpackage

### rtl/gtpp_marks.sv
// Visited mark store: two one-bit memories with forwarding of the last set.
module gtpp_marks (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gtpp_pkg::mark_wr_t wr_i,
  input  gtpp_pkg::mark_rd_t rd_i,
  output logic               visited_first_o,
  output logic               visited_second_o
);
  import gtpp_pkg::*;

  // A pair sets its first triangle in bank A and its second in bank B, so each
  // bank takes one write a cycle. A triangle is visited if either bank holds it.
  logic mem_a [TriangleCapacity];
  logic mem_b [TriangleCapacity];

  logic     a_first_q, a_second_q, b_first_q, b_second_q;
  tri_idx_t rd_first_q, rd_second_q;
  logic     fwd_valid_q, fwd_valid_d;
  tri_idx_t fwd_first_q, fwd_second_q;
  logic     hit_first, hit_second;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_a[wr_i.first]  <= wr_i.set;
      mem_b[wr_i.second] <= wr_i.set;
    end
    if (rd_i.en) begin
      a_first_q   <= mem_a[rd_i.first];
      a_second_q  <= mem_a[rd_i.second];
      b_first_q   <= mem_b[rd_i.first];
      b_second_q  <= mem_b[rd_i.second];
      rd_first_q  <= rd_i.first;
      rd_second_q <= rd_i.second;
    end
  end

  // The last set stays forwarded until a clear; a read taken on the same
  // edge as that write would otherwise miss it.
  always_comb begin
    fwd_valid_d = fwd_valid_q;
    if (wr_i.en) begin
      fwd_valid_d = wr_i.set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.set) begin
      fwd_first_q  <= wr_i.first;
      fwd_second_q <= wr_i.second;
    end
  end

  assign hit_first  = fwd_valid_q &&
                      ((rd_first_q == fwd_first_q) || (rd_first_q == fwd_second_q));
  assign hit_second = fwd_valid_q &&
                      ((rd_second_q == fwd_first_q) || (rd_second_q == fwd_second_q));

  assign visited_first_o  = a_first_q | b_first_q | hit_first;
  assign visited_second_o = a_second_q | b_second_q | hit_second;

endmodule

### rtl/greedy_triangle_pair_partition.sv
// Top level of the greedy triangle pair partition block.
//
// Requests enter on the input channel (in_valid_i / in_ready_o) with a
// function code and one or two triangle indices. Results leave on the output
// channel (out_valid_o / out_ready_i); a request gives zero or one result.
// The user writes the triangle count register (cfg_we_i / cfg_wdata_i) while the
// block is idle, not enforced by the block; a larger count acts as the capacity.
//
// An accepted request sits in one stage register while the mark store returns
// both marks; its result is loaded into the output register when the request
// commits. The block takes one request per cycle as long as the output
// register drains.
//
// A restart request, and reset itself, start a clearing pass that walks the
// 1024 mark entries one per cycle; in_ready_o stays low for the whole pass.
// After a restart it is also low while the restart sits in the stage register.
// The pair counter clears at once.
//
// When the receiver stalls, the finished result waits in the output register.
// A request that gives no result still passes; one that gives a result holds
// in the stage register, and in_ready_o drops until the output drains.
module greedy_triangle_pair_partition (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gtpp_pkg::CountW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gtpp_pkg::FuncW-1:0]         func_i,
  input  logic [gtpp_pkg::TriIdxW-1:0]       first_triangle_i,
  input  logic [gtpp_pkg::TriIdxW-1:0]       second_triangle_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gtpp_pkg::KindW-1:0]         kind_o,
  output logic [gtpp_pkg::PairCountBits-1:0] pair_number_o,
  output logic [gtpp_pkg::TriIdxW-1:0]       triangle_number_o
);
  import gtpp_pkg::*;

  // Configuration register.
  logic [CountW-1:0] tri_count_q;
  logic [CountW-1:0] live_count;

  // Stage register holding the request under evaluation.
  logic             s1_valid_q, s1_valid_d;
  logic [FuncW-1:0] s1_func_q;
  tri_idx_t         s1_first_q, s1_second_q;

  // Clearing pass over the mark store.
  logic     clear_q, clear_d;
  tri_idx_t clear_addr_q, clear_addr_d;

  logic [PairCountBits-1:0] pair_cnt_q, pair_cnt_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  kind_e                    out_kind_q;
  logic [PairCountBits-1:0] out_pair_q;
  tri_idx_t                 out_tri_q;

  logic     accept, commit;
  logic     first_ok, second_ok;
  logic     visited_first, visited_second;
  logic     res_valid, set_marks, restart;
  kind_e    res_kind;
  logic [PairCountBits-1:0] res_pair;
  tri_idx_t res_tri;
  logic     pair_step;

  mark_wr_t mark_wr;
  mark_rd_t mark_rd;

  assign live_count = (tri_count_q > TriCountMax) ? TriCountMax : tri_count_q;
  assign first_ok   = {1'b0, s1_first_q} < live_count;
  assign second_ok  = {1'b0, s1_second_q} < live_count;

  // Classification of the staged request. The first index is checked before
  // the second; an out-of-range index reports that index and changes nothing.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_ERROR;
    res_pair  = '0;
    res_tri   = '0;
    set_marks = 1'b0;
    restart   = 1'b0;
    pair_step = 1'b0;
    unique case (s1_func_q)
      FuncPair: begin
        res_valid = 1'b1;
        if (!first_ok) begin
          res_tri = s1_first_q;
        end else if (!second_ok) begin
          res_tri = s1_second_q;
        end else begin
          pair_step = 1'b1;
          res_pair  = pair_cnt_q;
          set_marks = !visited_first && !visited_second;
          res_kind  = set_marks ? KIND_SHARED : KIND_NONSHARED;
        end
      end
      FuncQuery: begin
        res_tri = s1_first_q;
        if (!first_ok) begin
          res_valid = 1'b1;
        end else if (!visited_first) begin
          res_valid = 1'b1;
          res_kind  = KIND_UNVISITED;
        end
      end
      FuncRestart: begin
        restart = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The staged request leaves when its result has room, or when it has none.
  assign commit     = s1_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  // A restart must finish its clearing pass before the next request reads marks.
  assign in_ready_o = !clear_q && (!s1_valid_q || (commit && !restart));
  assign accept     = in_valid_i && in_ready_o;

  assign mark_rd.en     = accept;
  assign mark_rd.first  = first_triangle_i;
  assign mark_rd.second = second_triangle_i;

  always_comb begin
    mark_wr.en     = 1'b0;
    mark_wr.set    = 1'b0;
    mark_wr.first  = s1_first_q;
    mark_wr.second = s1_second_q;
    if (clear_q) begin
      mark_wr.en     = 1'b1;
      mark_wr.first  = clear_addr_q;
      mark_wr.second = clear_addr_q;
    end else if (commit && set_marks) begin
      mark_wr.en  = 1'b1;
      mark_wr.set = 1'b1;
    end
  end

  gtpp_marks u_marks (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_i             (mark_wr),
    .rd_i             (mark_rd),
    .visited_first_o  (visited_first),
    .visited_second_o (visited_second)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    clear_d      = clear_q;
    clear_addr_d = clear_addr_q;
    if (clear_q) begin
      clear_addr_d = clear_addr_q + 1'b1;
      if (clear_addr_q == LastTriIdx) begin
        clear_d = 1'b0;
      end
    end else if (commit && restart) begin
      clear_d      = 1'b1;
      clear_addr_d = '0;
    end
  end

  // The pair counter saturates at its largest value.
  always_comb begin
    pair_cnt_d = pair_cnt_q;
    if (commit && restart) begin
      pair_cnt_d = '0;
    end else if (commit && pair_step && (pair_cnt_q != PairCountMax)) begin
      pair_cnt_d = pair_cnt_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_count_q  <= TriCountReset;
      s1_valid_q   <= 1'b0;
      clear_q      <= 1'b1;
      clear_addr_q <= '0;
      pair_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tri_count_q <= cfg_wdata_i;
      end
      s1_valid_q   <= s1_valid_d;
      clear_q      <= clear_d;
      clear_addr_q <= clear_addr_d;
      pair_cnt_q   <= pair_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q   <= func_i;
      s1_first_q  <= first_triangle_i;
      s1_second_q <= second_triangle_i;
    end
    if (commit && res_valid) begin
      out_kind_q <= res_kind;
      out_pair_q <= res_pair;
      out_tri_q  <= res_tri;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_kind_q;
  assign pair_number_o     = out_pair_q;
  assign triangle_number_o = out_tri_q;

endmodule

### rtl/gtpp_checker.sv
// Port-level checks of the greedy triangle pair partition block and their bind.
module gtpp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [gtpp_pkg::FuncW-1:0]         func_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [gtpp_pkg::KindW-1:0]         kind_o,
  input logic [gtpp_pkg::PairCountBits-1:0] pair_number_o,
  input logic [gtpp_pkg::TriIdxW-1:0]       triangle_number_o
);
  import gtpp_pkg::*;

  // A result that is not taken stays offered with the same fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(kind_o) && $stable(pair_number_o) && $stable(triangle_number_o))
    else $error("stalled result changed or dropped");

  // Pair results carry no triangle number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_SHARED || kind_o == KIND_NONSHARED) |->
      triangle_number_o == '0)
    else $error("pair result with a triangle number");

  // Unvisited and error results carry no pair number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_UNVISITED || kind_o == KIND_ERROR) |->
      pair_number_o == '0)
    else $error("triangle result with a pair number");

  // A restart blocks new requests while it sits in the stage register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FuncRestart |=> !in_ready_o)
    else $error("request taken right behind a restart");

endmodule

bind greedy_triangle_pair_partition gtpp_checker u_gtpp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .func_i            (func_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .kind_o            (kind_o),
  .pair_number_o     (pair_number_o),
  .triangle_number_o (triangle_number_o)
);
